/* rtl/olad_pkg.sv */
// shared types and constants for the ordered list core
// used by the controller, datapath and top modules of the block, depends on nothing
package olad_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;

	typedef enum logic [1:0] {
		CMD_APPEND   = 2'd0,
		CMD_DELETE   = 2'd1,
		CMD_TRAVERSE = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_APPENDED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_ELEMENT   = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ELEM_VAL   = 2'd0,
		ELEM_RDATA = 2'd1,
		ELEM_ZERO  = 2'd2
	} elem_sel_t;

	typedef struct packed {
		logic      load;
		logic      idx_clr;
		logic      idx_inc;
		logic      rd_en;
		logic      rd_next;
		logic      wr_en;
		logic      wr_shift;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      emit;
		status_t   status;
		elem_sel_t elem_sel;
		logic      last;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic match;
		logic idx_at_cnt;
		logic idx_last;
	} dp_stat_t;

endpackage

/* rtl/olad_ram.sv */
// generic single write, single read ram with registered read data
// no package dependency
module olad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/olad_dp.sv */
// datapath: entry store, fill count, scan index, result registers
// depends on olad_pkg and olad_ram
module olad_dp #(
	parameter int CAPACITY = olad_pkg::CAPACITY_DEF,
	localparam int CNT_W  = $clog2(CAPACITY + 1),
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  olad_pkg::dp_cmd_t          cmd,
	output olad_pkg::dp_stat_t         stat,
	input  logic signed [31:0]         value,
	output logic                       strobe,
	output logic [2:0]                 status,
	output logic signed [31:0]         element,
	output logic                       last
);

	logic [31:0]       val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W:0]    idx_p1;
	logic              strobe_q;
	logic [2:0]        status_q;
	logic [31:0]       element_q;
	logic              last_q;
	logic [31:0]       rdata;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       wdata;
	logic [31:0]       elem_d;

	assign idx_p1 = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};

	assign waddr = cmd.wr_shift ? idx_q[ADDR_W-1:0] : cnt_q[ADDR_W-1:0];
	assign wdata = cmd.wr_shift ? rdata : val_q;
	assign raddr = cmd.rd_next ? idx_p1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	olad_ram #(
		.WIDTH(olad_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		stat.full       = (cnt_q == CNT_W'(CAPACITY));
		stat.empty      = (cnt_q == '0);
		stat.match      = (rdata == val_q);
		stat.idx_at_cnt = (idx_q == cnt_q);
		stat.idx_last   = (idx_p1 == {1'b0, cnt_q});
	end

	always_comb begin
		unique case (cmd.elem_sel)
			olad_pkg::ELEM_VAL:   elem_d = val_q;
			olad_pkg::ELEM_RDATA: elem_d = rdata;
			default:              elem_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1[CNT_W-1:0];
			end
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
		end
		if (cmd.emit) begin
			status_q  <= cmd.status;
			element_q <= elem_d;
			last_q    <= cmd.last;
		end
	end

	assign strobe  = strobe_q;
	assign status  = status_q;
	assign element = element_q;
	assign last    = last_q;

endmodule

/* rtl/olad_ctrl.sv */
// controller state machine sequencing append, delete and traverse
// depends on olad_pkg
module olad_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         cmd,
	output logic               busy,
	input  olad_pkg::dp_stat_t stat,
	output olad_pkg::dp_cmd_t  dp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_APP,
		S_DEL_RD,
		S_DEL_CHK,
		S_SH_RD,
		S_SH_WR,
		S_TRAV_RD,
		S_TRAV_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		dp          = '0;
		dp.status   = olad_pkg::ST_APPENDED;
		dp.elem_sel = olad_pkg::ELEM_VAL;
		dp.last     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					dp.load    = 1'b1;
					dp.idx_clr = 1'b1;
					unique case (olad_pkg::cmd_t'(cmd))
						olad_pkg::CMD_APPEND:   state_d = S_APP;
						olad_pkg::CMD_DELETE:   state_d = S_DEL_RD;
						olad_pkg::CMD_TRAVERSE: state_d = S_TRAV_RD;
						default:                state_d = S_IDLE;
					endcase
				end
			end
			S_APP: begin
				dp.emit = 1'b1;
				if (stat.full) begin
					dp.status = olad_pkg::ST_FULL;
				end else begin
					dp.wr_en   = 1'b1;
					dp.cnt_inc = 1'b1;
					dp.status  = olad_pkg::ST_APPENDED;
				end
				state_d = S_IDLE;
			end
			S_DEL_RD: begin
				if (stat.idx_at_cnt) begin
					dp.emit   = 1'b1;
					dp.status = olad_pkg::ST_NOT_FOUND;
					state_d   = S_IDLE;
				end else begin
					dp.rd_en = 1'b1;
					state_d  = S_DEL_CHK;
				end
			end
			S_DEL_CHK: begin
				if (stat.match) begin
					state_d = S_SH_RD;
				end else begin
					dp.idx_inc = 1'b1;
					state_d    = S_DEL_RD;
				end
			end
			S_SH_RD: begin
				if (stat.idx_last) begin
					dp.cnt_dec = 1'b1;
					dp.emit    = 1'b1;
					dp.status  = olad_pkg::ST_DELETED;
					state_d    = S_IDLE;
				end else begin
					dp.rd_en   = 1'b1;
					dp.rd_next = 1'b1;
					state_d    = S_SH_WR;
				end
			end
			S_SH_WR: begin
				dp.wr_en    = 1'b1;
				dp.wr_shift = 1'b1;
				dp.idx_inc  = 1'b1;
				state_d     = S_SH_RD;
			end
			S_TRAV_RD: begin
				if (stat.empty) begin
					dp.emit     = 1'b1;
					dp.status   = olad_pkg::ST_EMPTY;
					dp.elem_sel = olad_pkg::ELEM_ZERO;
					state_d     = S_IDLE;
				end else begin
					dp.rd_en = 1'b1;
					state_d  = S_TRAV_OUT;
				end
			end
			S_TRAV_OUT: begin
				dp.emit     = 1'b1;
				dp.status   = olad_pkg::ST_ELEMENT;
				dp.elem_sel = olad_pkg::ELEM_RDATA;
				dp.last     = stat.idx_last;
				if (stat.idx_last) begin
					state_d = S_IDLE;
				end else begin
					dp.idx_inc = 1'b1;
					state_d    = S_TRAV_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* rtl/ordered_list_append_delete_core.sv */
// ordered list core: bounded head-to-tail list of signed 32-bit words
// command channel in, strobed result channel out
// depends on olad_pkg, olad_ctrl, olad_dp, olad_ram
//
// a command word (cmd, value) is taken at a rising edge with start high and
// busy low. results leave on status, element and last, each valid for the
// single cycle in which strobe is high; the receiver cannot stall them, and
// last marks the final result of a command.
// append: one result, strobed via the S_APP state and the strobe register; busy
//   for one cycle.
// delete: scans entries up to the match, each entry read then checked, then
//   moves each entry behind it up by one, each entry read then written; one
//   result at the end.
// traverse: one result per entry, each entry read then output, or one result
//   with list empty status.
// these steps come from the one-read-port registered read of the entry store:
//   each step reads one entry and uses it in the following cycle.
// command code 3 is dropped with no result.
// reset empties the list at once; store contents are not cleared.
module ordered_list_append_delete_core #(
	parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	output logic               busy,
	output logic               strobe,
	output logic [2:0]         status,
	output logic signed [31:0] element,
	output logic               last
);

	olad_pkg::dp_cmd_t  dp_cmd;
	olad_pkg::dp_stat_t dp_stat;

	olad_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.stat  (dp_stat),
		.dp    (dp_cmd)
	);

	olad_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.value  (value),
		.strobe (strobe),
		.status (status),
		.element(element),
		.last   (last)
	);

endmodule
